FILE: hw/rtl/bog_pkg.sv
// Shared types, codes and defaults for the badge occupancy gate.
package bog_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int NUM_LEDS_DEF  = 7;
    localparam int CAP_W         = 5;
    localparam int LED_SAT       = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd9;
    localparam logic [CAP_W-1:0] OCC_MAX   = 5'd31;

    typedef enum logic {
        OP_SCAN = 1'b0,
        OP_LOAD = 1'b1
    } bog_op_t;

    typedef enum logic [2:0] {
        ST_LOADED  = 3'd0,
        ST_UNKNOWN = 3'd1,
        ST_ENTRY   = 3'd2,
        ST_FULL    = 3'd3,
        ST_EXIT    = 3'd4
    } bog_status_t;

    typedef struct packed {
        bog_op_t     op;
        logic [31:0] badge_uid;
        logic [3:0]  slot;
        logic        slot_active;
    } bog_req_t;

    typedef struct packed {
        bog_status_t status;
        logic [3:0]  matched_slot;
        logic [15:0] badge_scans;
        logic [4:0]  occupancy;
        logic [15:0] entry_total;
        logic [15:0] exit_total;
        logic [2:0]  lit_leds;
    } bog_res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SWEEP,
        S_RESOLVE,
        S_DIV_INIT,
        S_DIV_RUN,
        S_OUT
    } bog_state_t;

    typedef struct packed {
        logic accept;
        logic load_wr;
        logic sweep_start;
        logic sweep_run;
        logic match_latch;
        logic commit;
        logic div_init;
        logic div_step;
        logic out_load;
    } bog_cmd_t;

    typedef struct packed {
        logic is_load;
        logic sweep_done;
        logic div_done;
        logic out_free;
    } bog_sts_t;

endpackage

FILE: hw/rtl/bog_ctrl.sv
// Sequencer for the badge gate: request intake, table sweep, update, bargraph, result.
module bog_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bog_pkg::bog_sts_t sts,
    output bog_pkg::bog_cmd_t cmd
);

    bog_pkg::bog_state_t state_reg;
    bog_pkg::bog_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bog_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            bog_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = bog_pkg::S_START;
                end
            end
            bog_pkg::S_START:
            begin
                if (sts.is_load)
                begin
                    cmd.load_wr = 1'b1;
                    state_next  = bog_pkg::S_DIV_INIT;
                end
                else
                begin
                    cmd.sweep_start = 1'b1;
                    state_next      = bog_pkg::S_SWEEP;
                end
            end
            bog_pkg::S_SWEEP:
            begin
                cmd.sweep_run = 1'b1;
                if (sts.sweep_done)
                begin
                    cmd.match_latch = 1'b1;
                    state_next      = bog_pkg::S_RESOLVE;
                end
            end
            bog_pkg::S_RESOLVE:
            begin
                cmd.commit = 1'b1;
                state_next = bog_pkg::S_DIV_INIT;
            end
            bog_pkg::S_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = bog_pkg::S_DIV_RUN;
            end
            bog_pkg::S_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = bog_pkg::S_OUT;
                end
            end
            bog_pkg::S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = bog_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bog_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/bog_datapath.sv
// Badge table, presence and counters, bargraph divider and result register.
module bog_datapath #(
    parameter int NUM_SLOTS = bog_pkg::NUM_SLOTS_DEF,
    parameter int NUM_LEDS  = bog_pkg::NUM_LEDS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bog_pkg::bog_req_t           in_req,
    input  logic                        cfg_we,
    input  logic [bog_pkg::CAP_W-1:0]   cfg_wdata,
    input  bog_pkg::bog_cmd_t           cmd,
    output bog_pkg::bog_sts_t           sts,
    output logic                        out_valid,
    input  logic                        out_ready,
    output bog_pkg::bog_res_t           out_res
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int OCC_W = $clog2(NUM_SLOTS + 1);
    localparam int LED_W = $clog2(NUM_LEDS + 1);
    localparam int NUM_W = bog_pkg::CAP_W + LED_W;
    localparam int LIM   = (NUM_LEDS < bog_pkg::LED_SAT) ? NUM_LEDS : bog_pkg::LED_SAT;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    logic [31:0]              ids_mem [NUM_SLOTS];
    logic [15:0]              scan_mem [NUM_SLOTS];

    bog_pkg::bog_req_t        req_reg;
    logic [bog_pkg::CAP_W-1:0] cap_reg;
    logic [NUM_SLOTS-1:0]     enabled_reg;
    logic [NUM_SLOTS-1:0]     present_reg;
    logic [OCC_W-1:0]         occ_reg;
    logic [15:0]              entry_reg;
    logic [15:0]              exit_reg;

    logic [IDX_W-1:0]         rd_idx_reg;
    logic [IDX_W-1:0]         cmp_idx_reg;
    logic                     cmp_vld_reg;
    logic [31:0]              id_rd_reg;
    logic                     found_reg;
    logic [IDX_W-1:0]         match_reg;
    logic [15:0]              scan_rd_reg;

    bog_pkg::bog_status_t     status_reg;
    logic [3:0]               mslot_reg;
    logic [15:0]              scans_reg;

    logic [NUM_W-1:0]         rem_reg;
    logic [2:0]               q_reg;

    bog_pkg::bog_res_t        out_res_reg;
    logic                     out_valid_reg;

    logic                     slot_ok;
    logic [IDX_W-1:0]         slot_idx;
    logic                     hit_now;
    logic                     last_now;
    logic [bog_pkg::CAP_W-1:0] occ_sat;
    bog_pkg::bog_status_t     outcome;
    logic [15:0]              scans_inc;
    logic                     moves;
    logic                     scan_we;
    logic [IDX_W-1:0]         scan_waddr;
    logic [15:0]              scan_wdata;
    logic [NUM_W-1:0]         cap_eff;
    logic [NUM_W-1:0]         num;
    logic                     div_done;

    assign slot_ok  = 32'(req_reg.slot) < NUM_SLOTS;
    assign slot_idx = IDX_W'(req_reg.slot);
    assign hit_now  = cmp_vld_reg && enabled_reg[cmp_idx_reg]
                      && (id_rd_reg == req_reg.badge_uid);
    assign last_now = cmp_vld_reg && (cmp_idx_reg == LAST_IDX);
    assign occ_sat  = (32'(occ_reg) > 32'(bog_pkg::OCC_MAX)) ? bog_pkg::OCC_MAX
                                                              : bog_pkg::CAP_W'(occ_reg);
    assign scans_inc = scan_rd_reg + 16'd1;

    always_comb
    begin
        if (!found_reg)
        begin
            outcome = bog_pkg::ST_UNKNOWN;
        end
        else if (present_reg[match_reg])
        begin
            outcome = bog_pkg::ST_EXIT;
        end
        else if (occ_sat >= cap_reg)
        begin
            outcome = bog_pkg::ST_FULL;
        end
        else
        begin
            outcome = bog_pkg::ST_ENTRY;
        end
    end

    assign moves = (outcome == bog_pkg::ST_ENTRY) || (outcome == bog_pkg::ST_EXIT);

    always_comb
    begin
        scan_we    = 1'b0;
        scan_waddr = match_reg;
        scan_wdata = scans_inc;
        if (cmd.load_wr)
        begin
            scan_we    = slot_ok;
            scan_waddr = slot_idx;
            scan_wdata = 16'd0;
        end
        else if (cmd.commit)
        begin
            scan_we = moves;
        end
    end

    assign cap_eff  = (cap_reg == '0) ? NUM_W'(1) : NUM_W'(cap_reg);
    assign num      = NUM_W'(occ_sat) * NUM_W'(NUM_LEDS);
    assign div_done = (q_reg == 3'(LIM)) || (rem_reg < cap_eff);

    // table memories
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && slot_ok)
        begin
            ids_mem[slot_idx] <= req_reg.badge_uid;
        end
        if (scan_we)
        begin
            scan_mem[scan_waddr] <= scan_wdata;
        end
        if (cmd.sweep_run)
        begin
            id_rd_reg <= ids_mem[rd_idx_reg];
        end
        if (cmd.match_latch)
        begin
            scan_rd_reg <= scan_mem[cmp_idx_reg];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg <= in_req;
        end
        if (cmd.sweep_start)
        begin
            rd_idx_reg <= '0;
        end
        else if (cmd.sweep_run)
        begin
            cmp_idx_reg <= rd_idx_reg;
            if (rd_idx_reg != LAST_IDX)
            begin
                rd_idx_reg <= rd_idx_reg + IDX_W'(1);
            end
        end
        if (cmd.match_latch)
        begin
            found_reg <= hit_now;
            match_reg <= cmp_idx_reg;
        end
        if (cmd.load_wr)
        begin
            status_reg <= bog_pkg::ST_LOADED;
            mslot_reg  <= 4'd0;
            scans_reg  <= 16'd0;
        end
        else if (cmd.commit)
        begin
            status_reg <= outcome;
            mslot_reg  <= found_reg ? 4'(match_reg) : 4'd0;
            scans_reg  <= !found_reg ? 16'd0 : (moves ? scans_inc : scan_rd_reg);
        end
        if (cmd.div_init)
        begin
            rem_reg <= num;
            q_reg   <= 3'd0;
        end
        else if (cmd.div_step && !div_done)
        begin
            rem_reg <= rem_reg - cap_eff;
            q_reg   <= q_reg + 3'd1;
        end
        if (cmd.out_load)
        begin
            out_res_reg.status       <= status_reg;
            out_res_reg.matched_slot <= mslot_reg;
            out_res_reg.badge_scans  <= scans_reg;
            out_res_reg.occupancy    <= occ_sat;
            out_res_reg.entry_total  <= entry_reg;
            out_res_reg.exit_total   <= exit_reg;
            out_res_reg.lit_leds     <= q_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= bog_pkg::CAP_RESET;
            enabled_reg   <= '0;
            present_reg   <= '0;
            occ_reg       <= '0;
            entry_reg     <= '0;
            exit_reg      <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (cmd.sweep_start)
            begin
                cmp_vld_reg <= 1'b0;
            end
            else if (cmd.sweep_run)
            begin
                cmp_vld_reg <= 1'b1;
            end
            if (cmd.load_wr && slot_ok)
            begin
                enabled_reg[slot_idx] <= req_reg.slot_active;
                present_reg[slot_idx] <= 1'b0;
                if (present_reg[slot_idx])
                begin
                    occ_reg <= occ_reg - OCC_W'(1);
                end
            end
            else if (cmd.commit)
            begin
                if (outcome == bog_pkg::ST_ENTRY)
                begin
                    present_reg[match_reg] <= 1'b1;
                    occ_reg                <= occ_reg + OCC_W'(1);
                    entry_reg              <= entry_reg + 16'd1;
                end
                else if (outcome == bog_pkg::ST_EXIT)
                begin
                    present_reg[match_reg] <= 1'b0;
                    occ_reg                <= occ_reg - OCC_W'(1);
                    exit_reg               <= exit_reg + 16'd1;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.is_load    = (req_reg.op == bog_pkg::OP_LOAD);
    assign sts.sweep_done = hit_now || last_now;
    assign sts.div_done   = div_done;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

FILE: hw/rtl/badge_occupancy_gate_top.sv
// Top level of the badge occupancy gate: sequencer plus datapath.
//
// One request is handled at a time. A load writes the table and then runs
// the bargraph divider; a scan first runs the table sweep, which reads one
// UID per cycle from the ID memory and stops at the first active match,
// then the update and the bargraph divider, which subtracts the capacity
// once per cycle for up to min(NUM_LEDS,7) steps. Either then waits in
// S_OUT while a previous result still waits in the result register.
// The result register lets the next request be accepted while a result
// waits. The user writes room_capacity (reset 9) via cfg_we/cfg_wdata
// only while the block is idle; the block does not enforce this. A capacity of zero denies every entry.
module badge_occupancy_gate_top #(
    parameter int NUM_SLOTS = bog_pkg::NUM_SLOTS_DEF,
    parameter int NUM_LEDS  = bog_pkg::NUM_LEDS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  bog_pkg::bog_req_t         in_req,
    output logic                      out_valid,
    input  logic                      out_ready,
    output bog_pkg::bog_res_t         out_res,
    input  logic                      cfg_we,
    input  logic [bog_pkg::CAP_W-1:0] cfg_wdata
);

    bog_pkg::bog_cmd_t cmd;
    bog_pkg::bog_sts_t sts;

    bog_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bog_datapath #(
        .NUM_SLOTS (NUM_SLOTS),
        .NUM_LEDS  (NUM_LEDS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_req    (in_req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

endmodule
